// ----- rtl/ptcf_pkg.sv -----
`timescale 1ns / 1ps
// ptcf_pkg: shared widths, codes and types of the pulse train capture framer
// no dependencies; imported by every module of the block but ptcf_ram

package ptcf_pkg;

  // default frame capacity (intervals per frame)
  localparam int MAX_FRAME_DEF = 64;

  // field widths
  localparam int TIME_W      = 32;
  localparam int INTERVAL_W  = 16;
  localparam int POS_W       = 6;
  localparam int PULSE_W     = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // descriptor queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // interval saturation and register reset values
  localparam logic [INTERVAL_W-1:0] SAT_LIMIT        = 16'hFFFF;
  localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RST = 16'hFFFF;
  localparam logic [PULSE_W-1:0]    MAX_PULSES_RST   = 7'd64;

  // item kinds
  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_MIN_INTERVAL = 3'd1,
    REG_MAX_INTERVAL = 3'd2,
    REG_MIN_PULSES   = 3'd3,
    REG_MAX_PULSES   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                  enable;
    logic [INTERVAL_W-1:0] min_interval;
    logic [INTERVAL_W-1:0] max_interval;
    logic [PULSE_W-1:0]    min_pulses;
    logic [PULSE_W-1:0]    max_pulses;
  } cfg_t;

  // a closed frame waiting to be sent
  typedef struct packed {
    logic               bank;
    logic               level;
    logic [PULSE_W-1:0] count;
  } desc_t;

  // back hands a store bank back to the front
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

endpackage

// ----- rtl/ptcf_ram.sv -----
`timescale 1ns / 1ps
// ptcf_ram: generic single write, single read RAM with registered read data
// no dependencies

module ptcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/ptcf_front.sv -----
`timescale 1ns / 1ps
// ptcf_front: accepts edge and poll beats, measures intervals, writes the store
// and hands closed frames to the queue; depends on ptcf_pkg

module ptcf_front import ptcf_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfg_t                         cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  op_t                          in_op,
  input  logic                         in_level,
  input  logic [TIME_W-1:0]            in_time,
  input  release_t                     rel,
  output logic                         wr_en,
  output logic [$clog2(MAX_FRAME):0]   wr_addr,
  output logic [INTERVAL_W-1:0]        wr_data,
  output logic                         push,
  output desc_t                        push_desc,
  output logic [1:0]                   busy
);

  localparam int IDX_W = $clog2(MAX_FRAME);
  localparam int CW    = $clog2(MAX_FRAME + 1);

  logic              frame_open_r, frame_open_nxt;
  logic              open_level_r, open_level_nxt;
  logic              prev_level_r, prev_level_nxt;
  logic [TIME_W-1:0] prev_time_r, prev_time_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              wbank_r, wbank_nxt;
  logic [1:0]        busy_r, busy_nxt;

  logic [TIME_W-1:0]     elapsed;
  logic [INTERVAL_W-1:0] iv;
  logic [CW-1:0]         cnt_inc;
  logic                  accept, poll_go, take, open_frame, lvl_take, close, keep;

  // interval since the previous edge, saturated
  assign elapsed = in_time - prev_time_r;
  assign iv      = (elapsed >= TIME_W'(SAT_LIMIT)) ? SAT_LIMIT : elapsed[INTERVAL_W-1:0];
  assign cnt_inc = count_r + CW'(1);

  // classify the beat
  assign accept     = in_valid && in_ready && cfg.enable;
  assign poll_go    = frame_open_r && (count_r != '0) &&
                      (elapsed >= TIME_W'(cfg.max_interval));
  assign take       = accept && (((in_op == OP_EDGE) && frame_open_r) ||
                                 ((in_op == OP_POLL) && poll_go));
  assign open_frame = accept && (in_op == OP_EDGE) && !frame_open_r;
  assign lvl_take   = (in_op == OP_EDGE) ? in_level : prev_level_r;

  // frame close and keep decisions
  assign close = (iv < cfg.min_interval) || (iv >= cfg.max_interval) ||
                 (PULSE_W'(cnt_inc) >= cfg.max_pulses) || (cnt_inc >= CW'(MAX_FRAME));
  assign keep  = PULSE_W'(cnt_inc) >= cfg.min_pulses;

  // store write and queue push
  assign in_ready          = !busy_r[wbank_r];
  assign wr_en             = take;
  assign wr_addr           = {wbank_r, count_r[IDX_W-1:0]};
  assign wr_data           = iv;
  assign push              = take && close && keep;
  assign push_desc.bank    = wbank_r;
  assign push_desc.level   = open_level_r;
  assign push_desc.count   = PULSE_W'(cnt_inc);
  assign busy              = busy_r;

  // next state of the frame tracker
  always_comb begin
    frame_open_nxt = frame_open_r;
    open_level_nxt = open_level_r;
    prev_level_nxt = prev_level_r;
    prev_time_nxt  = prev_time_r;
    count_nxt      = count_r;
    wbank_nxt      = wbank_r;
    busy_nxt       = busy_r;

    if (open_frame) begin
      frame_open_nxt = 1'b1;
      open_level_nxt = in_level;
      prev_level_nxt = in_level;
      prev_time_nxt  = in_time;
      count_nxt      = '0;
    end

    if (take) begin
      prev_time_nxt  = in_time;
      prev_level_nxt = lvl_take;
      if (close) begin
        open_level_nxt = lvl_take;
        count_nxt      = '0;
      end else begin
        count_nxt = cnt_inc;
      end
      // an idle poll re-arms capture
      if (in_op == OP_POLL) begin
        frame_open_nxt = 1'b0;
        count_nxt      = '0;
      end
    end

    // bank ownership: back releases, front claims on push
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_nxt[wbank_r] = 1'b1;
      wbank_nxt         = ~wbank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      open_level_r <= 1'b0;
      prev_level_r <= 1'b0;
      prev_time_r  <= '0;
      count_r      <= '0;
      wbank_r      <= 1'b0;
      busy_r       <= '0;
    end else begin
      frame_open_r <= frame_open_nxt;
      open_level_r <= open_level_nxt;
      prev_level_r <= prev_level_nxt;
      prev_time_r  <= prev_time_nxt;
      count_r      <= count_nxt;
      wbank_r      <= wbank_nxt;
      busy_r       <= busy_nxt;
    end
  end

endmodule

// ----- rtl/ptcf_queue.sv -----
`timescale 1ns / 1ps
// ptcf_queue: short fifo of closed frame descriptors between front and back
// depends on ptcf_pkg

module ptcf_queue import ptcf_pkg::*; (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  desc_t                              push_desc,
  input  logic                               pop,
  output desc_t                              head,
  output logic                               empty,
  output logic                               full,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head  = entry_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign count = count_r;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // descriptor storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ----- rtl/ptcf_back.sv -----
`timescale 1ns / 1ps
// ptcf_back: takes frame descriptors, reads the store bank and sends one beat
// per interval through a read stage and an output register; depends on ptcf_pkg

module ptcf_back import ptcf_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  desc_t                        q_head,
  output logic                         pop,
  output logic                         rd_en,
  output logic [$clog2(MAX_FRAME):0]   rd_addr,
  input  logic [INTERVAL_W-1:0]        rd_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_level,
  output logic [INTERVAL_W-1:0]        out_interval,
  output logic [POS_W-1:0]             out_pos,
  output logic                         out_last,
  output release_t                     rel,
  output logic                         emitting
);

  localparam int IDX_W = $clog2(MAX_FRAME);
  localparam int CW    = $clog2(MAX_FRAME + 1);

  back_state_t state_r, state_nxt;
  logic             bank_r, bank_nxt;
  logic             level_r, level_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // read stage (data sits in the ram read register)
  logic             s1_valid_r, s1_valid_nxt;
  logic [IDX_W-1:0] s1_pos_r;
  logic             s1_last_r;
  logic             s1_level_r;

  // output register
  logic                  out_valid_r;
  logic                  out_level_r;
  logic [INTERVAL_W-1:0] out_interval_r;
  logic [IDX_W-1:0]      out_pos_r;
  logic                  out_last_r;

  logic out_load, issue, is_final;

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign issue    = (state_r == BK_EMIT) && (!s1_valid_r || out_load);
  assign is_final = ((CW'(idx_r) + CW'(1)) == count_r);
  assign rd_addr  = {bank_r, idx_r};
  assign emitting = (state_r == BK_EMIT);

  // sequencer: pick up a descriptor, then issue one read per interval
  always_comb begin
    state_nxt = state_r;
    bank_nxt  = bank_r;
    level_nxt = level_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    rel.valid = 1'b0;
    rel.bank  = bank_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          bank_nxt  = q_head.bank;
          level_nxt = q_head.level;
          count_nxt = CW'(q_head.count);
          idx_nxt   = '0;
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (issue) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + IDX_W'(1);
          // last read issued: the bank may be refilled
          if (is_final) begin
            rel.valid = 1'b1;
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // frame context and stage payload
  always_ff @(posedge clk) begin
    bank_r  <= bank_nxt;
    level_r <= level_nxt;
    count_r <= count_nxt;
    idx_r   <= idx_nxt;
    if (issue) begin
      s1_pos_r   <= idx_r;
      s1_last_r  <= is_final;
      s1_level_r <= level_r;
    end
    if (out_load) begin
      out_level_r    <= s1_level_r;
      out_interval_r <= rd_data;
      out_pos_r      <= s1_pos_r;
      out_last_r     <= s1_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_level    = out_level_r;
  assign out_interval = out_interval_r;
  assign out_pos      = POS_W'(out_pos_r);
  assign out_last     = out_last_r;

endmodule

// ----- rtl/pulse_train_capture_framer.sv -----
`timescale 1ns / 1ps
// pulse_train_capture_framer: top level, configuration registers, store and
// front, queue and back; depends on ptcf_pkg, ptcf_ram, ptcf_front,
// ptcf_queue, ptcf_back
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid / in_tready  tuser op, tdata level, time_us
//   out_     master     out_tvalid/out_tready  tdata start_level, interval_us,
//                                              position; tlast last
//   cfg_     slave      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An edge that closes a frame of n kept intervals starts a burst of n beats,
// one a cycle while out_tready is high, passing the queue and the read stage.
// The store holds two banks of MAX_FRAME intervals: the front stalls only
// when both banks hold closed frames not yet read out by the back.
// Synchronous active-low reset; the store needs no clearing pass.
// Configuration writes are always taken (cfg_ready stays high).

module pulse_train_capture_framer import ptcf_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input beats
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] level, [32:1] time_us, rest zero
  input  logic                   in_tuser,   // [0] op
  // result beats
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] start_level, [16:1] interval_us,
                                             // [22:17] position, rest zero
  output logic                   out_tlast,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W   = $clog2(MAX_FRAME);
  localparam int AW      = IDX_W + 1;
  localparam int RAM_DEP = 2 * (1 << IDX_W);
  localparam int QCW     = $clog2(QUEUE_DEPTH + 1);

  cfg_t cfg_r;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [INTERVAL_W-1:0] wr_data, rd_data;
  logic                  push, pop, q_empty, q_full, emitting;
  logic [QCW-1:0]        q_count;
  desc_t                 push_desc, q_head;
  release_t              rel;
  logic [1:0]            busy;

  logic                  out_level, out_last_w;
  logic [INTERVAL_W-1:0] out_interval;
  logic [POS_W-1:0]      out_pos;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= 1'b0;
      cfg_r.min_interval <= '0;
      cfg_r.max_interval <= MAX_INTERVAL_RST;
      cfg_r.min_pulses   <= '0;
      cfg_r.max_pulses   <= MAX_PULSES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:       cfg_r.enable       <= cfg_data[0];
        REG_MIN_INTERVAL: cfg_r.min_interval <= cfg_data[INTERVAL_W-1:0];
        REG_MAX_INTERVAL: cfg_r.max_interval <= cfg_data[INTERVAL_W-1:0];
        REG_MIN_PULSES:   cfg_r.min_pulses   <= cfg_data[PULSE_W-1:0];
        REG_MAX_PULSES:   cfg_r.max_pulses   <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // front: classify beats and fill the store
  ptcf_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tuser)),
    .in_level  (in_tdata[0]),
    .in_time   (in_tdata[TIME_W:1]),
    .rel       (rel),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_desc (push_desc),
    .busy      (busy)
  );

  // interval store, two banks
  ptcf_ram #(.WIDTH(INTERVAL_W), .DEPTH(RAM_DEP)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // closed frames waiting for the back
  ptcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  // back: read out bursts
  ptcf_back #(.MAX_FRAME(MAX_FRAME)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (pop),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_level    (out_level),
    .out_interval (out_interval),
    .out_pos      (out_pos),
    .out_last     (out_last_w),
    .rel          (rel),
    .emitting     (emitting)
  );

  assign out_tdata = {1'b0, out_pos, out_interval, out_level};
  assign out_tlast = out_last_w;

  // a push never finds the queue full
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("descriptor pushed into a full queue");

  // every owned bank is either queued or being read out
  a_bank_owner: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(busy) == (int'(q_count) + int'(emitting)))
    else $error("bank ownership out of step with queue and back");

  // the back only hands back a bank the front gave away
  a_release_owned: assert property (@(posedge clk) disable iff (!rst_n)
    rel.valid |-> busy[rel.bank])
    else $error("release of a bank that is not owned");

endmodule

// ----- bench/tb_pulse_train_capture_framer.sv -----
`timescale 1ns / 1ps
// tb_pulse_train_capture_framer: self-checking bench for the pulse train capture
// framer, with an interval predictor, random stalls on both streams and register phases
// depends on ptcf_pkg and pulse_train_capture_framer

module tb_pulse_train_capture_framer;
  import ptcf_pkg::*;

  typedef struct packed {
    logic                  start_level;
    logic [INTERVAL_W-1:0] interval_us;
    logic [POS_W-1:0]      position;
    logic                  last;
  } interval_beat_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  reg_idx_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predictor copy of the registers
  logic                  cap_on;
  logic [INTERVAL_W-1:0] glitch_us;
  logic [INTERVAL_W-1:0] gap_us;
  logic [PULSE_W-1:0]    keep_min;
  logic [PULSE_W-1:0]    frame_cap;

  // predictor copy of the capture state
  logic                  frame_live;
  logic                  open_level;
  logic                  last_level;
  logic [TIME_W-1:0]     last_edge_us;
  logic [INTERVAL_W-1:0] held_iv [MAX_FRAME_DEF];
  int                    held_n;

  interval_beat_t frame_beats_due [$];
  int             mismatches;
  bit             steady;

  pulse_train_capture_framer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // store one interval ending at t, close the frame when a limit is hit
  function automatic void store_interval(logic [TIME_W-1:0] t, logic lvl);
    logic [TIME_W-1:0]     elapsed;
    logic [INTERVAL_W-1:0] iv;
    int                    cap;
    interval_beat_t        beat;
    elapsed = t - last_edge_us;
    iv = (elapsed >= {16'd0, SAT_LIMIT}) ? SAT_LIMIT : elapsed[INTERVAL_W-1:0];
    cap = (int'(frame_cap) > MAX_FRAME_DEF) ? MAX_FRAME_DEF : int'(frame_cap);
    last_edge_us = t;
    last_level = lvl;
    if (held_n < MAX_FRAME_DEF) begin
      held_iv[held_n] = iv;
      held_n++;
    end
    if (iv < glitch_us || iv >= gap_us || held_n >= cap || held_n >= MAX_FRAME_DEF) begin
      if (held_n >= int'(keep_min)) begin
        for (int k = 0; k < held_n; k++) begin
          beat.start_level = open_level;
          beat.interval_us = held_iv[k];
          beat.position    = k[POS_W-1:0];
          beat.last        = (k + 1 == held_n);
          frame_beats_due.insert(frame_beats_due.size(), beat);
        end
      end
      open_level = lvl;
      held_n = 0;
    end
  endfunction

  // advance the capture state by one accepted input beat
  function automatic void track_item(op_t op, logic lvl, logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] elapsed;
    if (!cap_on) return;
    if (op == OP_EDGE) begin
      if (!frame_live) begin
        frame_live = 1'b1;
        open_level = lvl;
        last_level = lvl;
        last_edge_us = t;
        held_n = 0;
      end else begin
        store_interval(t, lvl);
      end
    end else begin
      elapsed = t - last_edge_us;
      if (!frame_live || held_n == 0 || elapsed < {16'd0, gap_us}) return;
      store_interval(t, last_level);
      frame_live = 1'b0;
      held_n = 0;
    end
  endfunction

  // one register write beat; cfg_valid stays high for a following write
  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE:       cap_on    = value[0];
      REG_MIN_INTERVAL: glitch_us = value;
      REG_MAX_INTERVAL: gap_us    = value;
      REG_MIN_PULSES:   keep_min  = value[PULSE_W-1:0];
      REG_MAX_PULSES:   frame_cap = value[PULSE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic en, int unsigned lo_us, int unsigned hi_us,
                          int unsigned min_p, int unsigned max_p);
    write_reg(REG_ENABLE, {15'd0, en});
    write_reg(REG_MIN_INTERVAL, lo_us[CFG_DATA_W-1:0]);
    write_reg(REG_MAX_INTERVAL, hi_us[CFG_DATA_W-1:0]);
    write_reg(REG_MIN_PULSES, min_p[CFG_DATA_W-1:0]);
    write_reg(REG_MAX_PULSES, max_p[CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one input beat after a random gap; in_tvalid stays high afterwards
  task automatic send_item(op_t op, logic lvl, logic [TIME_W-1:0] t);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - TIME_W - 1){1'b0}}, t, lvl};
    do @(posedge clk); while (!in_tready);
    track_item(op, lvl, t);
  endtask

  // stop sending, let every due beat arrive, then allow the pipeline to empty
  task automatic settle;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (frame_beats_due.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // interval to the next edge, spread around the glitch and gap limits
  function automatic logic [TIME_W-1:0] pick_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom;
    if (r < 20 && glitch_us > 0) return $urandom_range(0, glitch_us - 1);
    if (r < 32) return $urandom_range(gap_us, gap_us + 3000);
    if (gap_us > glitch_us) return $urandom_range(glitch_us, gap_us - 1);
    return $urandom_range(0, 65535);
  endfunction

  // receiver: random stall before every result beat
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // compare each result beat with the oldest due interval
  always @(posedge clk) begin : check_beats
    interval_beat_t want;
    interval_beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.start_level = out_tdata[0];
      got.interval_us = out_tdata[16:1];
      got.position    = out_tdata[22:17];
      got.last        = out_tlast;
      if (frame_beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: level %0d interval %0d pos %0d last %0d",
                   got.start_level, got.interval_us, got.position, got.last);
      end else begin
        want = frame_beats_due[0];
        frame_beats_due.delete(0);
        if (got.start_level !== want.start_level || got.interval_us !== want.interval_us ||
            got.position !== want.position || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: expected level %0d interval %0d pos %0d last %0d, %s",
                     want.start_level, want.interval_us, want.position, want.last,
                     $sformatf("got level %0d interval %0d pos %0d last %0d",
                               got.start_level, got.interval_us, got.position, got.last));
        end
      end
    end
  end

  // items while capture is off change nothing
  task automatic test_disabled;
    send_item(OP_EDGE, 1'b1, 32'h0000_1000);
    send_item(OP_EDGE, 1'b0, 32'h0000_1400);
    send_item(OP_POLL, 1'b0, 32'hFFFF_0000);
    settle();
  endtask

  // hand-picked edges and polls: wrap, glitch, gap, pulse cap, idle close, saturation
  task automatic test_directed;
    logic [TIME_W-1:0] t;
    set_regs(1'b1, 10, 1000, 2, 4);
    t = 32'hFFFF_FFF0;
    send_item(OP_POLL, 1'b0, t);             // nothing open
    send_item(OP_EDGE, 1'b1, t);             // opens frame
    send_item(OP_POLL, 1'b1, t + 5000);      // only the opening edge held
    t = t + 32'h20;                          // wraps through zero
    send_item(OP_EDGE, 1'b0, t);
    send_item(OP_POLL, 1'b0, t + 500);       // not idle long enough
    t = t + 100;  send_item(OP_EDGE, 1'b1, t);
    t = t + 3;    send_item(OP_EDGE, 1'b0, t);  // glitch closes, kept
    t = t + 2000; send_item(OP_EDGE, 1'b1, t);  // gap closes, too short, dropped
    t = t + 10;   send_item(OP_EDGE, 1'b0, t);  // exactly the glitch limit
    t = t + 999;  send_item(OP_EDGE, 1'b1, t);  // just under the gap limit
    t = t + 50;   send_item(OP_EDGE, 1'b0, t);
    t = t + 60;   send_item(OP_EDGE, 1'b1, t);  // pulse cap reached at four
    t = t + 20;   send_item(OP_EDGE, 1'b0, t);
    t = t + 30;   send_item(OP_EDGE, 1'b1, t);
    send_item(OP_POLL, 1'b0, t + 999);
    send_item(OP_POLL, 1'b1, t + 1000);      // idle close, re-arm
    t = t + 32'h1234_5678; send_item(OP_EDGE, 1'b0, t);
    t = t + 32'h8000_0000; send_item(OP_EDGE, 1'b1, t);  // saturated interval
    send_item(OP_POLL, 1'b1, t + 32'h7FFF_FFFF);
    settle();
  endtask

  // register extremes: widest and narrowest limits, zero and oversize pulse counts
  task automatic test_register_extremes;
    logic [TIME_W-1:0] t;
    t = $urandom;
    set_regs(1'b1, 65535, 65535, 0, 64);
    send_item(OP_EDGE, 1'b0, t);
    t = t + 100;      send_item(OP_EDGE, 1'b1, t);
    send_item(OP_EDGE, 1'b0, t);
    t = t + 32'h10000; send_item(OP_EDGE, 1'b1, t);
    settle();
    set_regs(1'b1, 0, 0, 0, 64);
    t = t + 7;  send_item(OP_EDGE, 1'b0, t);
    t = t + 0;  send_item(OP_EDGE, 1'b1, t);
    send_item(OP_POLL, 1'b0, t + 40);
    settle();
    set_regs(1'b1, 0, 65535, 0, 0);
    t = t + 300; send_item(OP_EDGE, 1'b0, t);
    t = t + 400; send_item(OP_EDGE, 1'b1, t);
    settle();
    set_regs(1'b1, 0, 65535, 70, 2);
    t = t + 5;  send_item(OP_EDGE, 1'b0, t);
    t = t + 6;  send_item(OP_EDGE, 1'b1, t);
    t = t + 9;  send_item(OP_EDGE, 1'b0, t);
    settle();
    // oversize max_pulses acts as the store size; a full frame is exactly kept
    steady = 1'b1;
    set_regs(1'b1, 0, 65535, 64, 100);
    for (int i = 0; i < 65; i++) begin
      t = t + $urandom_range(0, 65534);
      send_item(OP_EDGE, i[0], t);
    end
    settle();
    steady = 1'b0;
  endtask

  // random trains under several register settings
  task automatic test_random_trains;
    logic [TIME_W-1:0] now_us;
    logic              lvl;
    int unsigned       r;
    logic [TIME_W-1:0] d;
    for (int p = 0; p < 6; p++) begin
      steady = (p % 3 == 2);
      set_regs(1'b1, (p == 1) ? 0 : $urandom_range(1, 200),
               (p == 3) ? 65535 : $urandom_range(400, 5000),
               $urandom_range(0, 4), (p == 4) ? 64 : $urandom_range(1, 12));
      now_us = $urandom;
      lvl = $urandom_range(0, 1);
      for (int i = 0; i < 14; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // noise: any kind at any time
          send_item(op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        end else if (r < 20) begin
          d = $urandom_range(0, 1) ? $urandom_range(0, gap_us)
                                   : $urandom_range(gap_us, gap_us + 500);
          now_us = now_us + d;
          send_item(OP_POLL, 1'($urandom_range(0, 1)), now_us);
        end else begin
          now_us = now_us + pick_delta();
          lvl = (r < 28) ? 1'($urandom_range(0, 1)) : ~lvl;
          send_item(OP_EDGE, lvl, now_us);
        end
      end
      settle();
    end
    steady = 1'b0;
  endtask

  // run limit
  initial begin
    #50_000_000;
    $display("tb_pulse_train_capture_framer: FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    steady = 1'b0;
    mismatches = 0;
    cap_on = 1'b0;
    glitch_us = '0;
    gap_us = MAX_INTERVAL_RST;
    keep_min = '0;
    frame_cap = MAX_PULSES_RST;
    frame_live = 1'b0;
    open_level = 1'b0;
    last_level = 1'b0;
    last_edge_us = '0;
    held_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_disabled();
    test_directed();
    test_register_extremes();
    test_random_trains();
    settle();

    if (mismatches == 0)
      $display("tb_pulse_train_capture_framer: PASS");
    else
      $display("tb_pulse_train_capture_framer: FAIL");
    $finish;
  end

endmodule
